// ----- rtl/bpi_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bpi_pkg: shared types and constants for box_pair_iou
// Field widths, the queue item and the divider stage record.
// ----------------------------------------------------------------------------
package bpi_pkg;

  localparam int COORD_BITS    = 12;
  localparam int IOU_FRAC_BITS = 16;

  localparam int INTER_BITS = 2 * COORD_BITS;
  localparam int UNION_BITS = 2 * COORD_BITS + 1;
  localparam int IOU_BITS   = IOU_FRAC_BITS + 1;
  localparam int SPACE_BITS = COORD_BITS + 1;
  localparam int REM_BITS   = UNION_BITS + 1;
  localparam int DIV_STAGES = IOU_FRAC_BITS + 1;

  localparam int IN_BITS   = 8 * COORD_BITS;
  localparam int IN_TDATA  = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS  = INTER_BITS + UNION_BITS + IOU_BITS + SPACE_BITS;
  localparam int OUT_TDATA = ((OUT_BITS + 7) / 8) * 8;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef logic [COORD_BITS-1:0] coord_t;

  // Classified item handed from front to back
  typedef struct packed {
    logic [INTER_BITS-1:0] inter;
    logic [UNION_BITS-1:0] uni;
    logic [SPACE_BITS-1:0] spacing;
  } item_t;

  // One divider stage: item plus partial remainder and quotient
  typedef struct packed {
    item_t               item;
    logic [REM_BITS-1:0] rem;
    logic [IOU_BITS-1:0] quo;
  } div_t;

endpackage
`default_nettype wire

// ----- rtl/bpi_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bpi_front: overlap, area and centre stages
// Two registered stages producing intersection, union and centre spacing.
// ----------------------------------------------------------------------------
module bpi_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [bpi_pkg::IN_BITS-1:0]   in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output bpi_pkg::item_t                     out_item_o
);
  localparam int C = bpi_pkg::COORD_BITS;

  bpi_pkg::coord_t ax, ay, aw, ah, bx, by, bw, bh;
  assign ax = in_data_i[0*C +: C];
  assign ay = in_data_i[1*C +: C];
  assign aw = in_data_i[2*C +: C];
  assign ah = in_data_i[3*C +: C];
  assign bx = in_data_i[4*C +: C];
  assign by = in_data_i[5*C +: C];
  assign bw = in_data_i[6*C +: C];
  assign bh = in_data_i[7*C +: C];

  logic en;
  logic s1_valid_q, s2_valid_q;
  bpi_pkg::coord_t ox_d, ox_q, oy_d, oy_q;
  logic [bpi_pkg::INTER_BITS-1:0] aa_d, aa_q, ab_d, ab_q;
  logic [bpi_pkg::SPACE_BITS-1:0] sp_d, sp_q;
  bpi_pkg::item_t item_d, item_q;

  // Whole front advances unless its last stage is blocked
  assign en         = !(s2_valid_q && !out_ready_i);
  assign in_ready_o = en;

  // Clamped span overlap: min end minus max start
  function automatic bpi_pkg::coord_t overlap(bpi_pkg::coord_t p1, bpi_pkg::coord_t l1,
                                              bpi_pkg::coord_t p2, bpi_pkg::coord_t l2);
    logic [C:0] e1, e2, mn, mx;
    e1 = {1'b0, p1} + {1'b0, l1};
    e2 = {1'b0, p2} + {1'b0, l2};
    mn = (e1 < e2) ? e1 : e2;
    mx = (p1 > p2) ? {1'b0, p1} : {1'b0, p2};
    return (mn > mx) ? C'(mn - mx) : '0;
  endfunction

  // Stage 1: overlaps, box areas, centre spacing
  logic [C:0] ca, cb;
  always_comb begin
    ox_d = overlap(ax, aw, bx, bw);
    oy_d = overlap(ay, ah, by, bh);
    aa_d = {{C{1'b0}}, aw} * {{C{1'b0}}, ah};
    ab_d = {{C{1'b0}}, bw} * {{C{1'b0}}, bh};
    ca   = {1'b0, ax} + (({1'b0, aw} + 1'b1) >> 1);
    cb   = {1'b0, bx} + (({1'b0, bw} + 1'b1) >> 1);
    sp_d = (ca > cb) ? (ca - cb) : (cb - ca);
  end

  // Stage 2: intersection product and union
  always_comb begin
    item_d.inter   = {{C{1'b0}}, ox_q} * {{C{1'b0}}, oy_q};
    item_d.uni     = {1'b0, aa_q} + {1'b0, ab_q} - {1'b0, item_d.inter};
    item_d.spacing = sp_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= in_valid_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ox_q   <= ox_d;
      oy_q   <= oy_d;
      aa_q   <= aa_d;
      ab_q   <= ab_d;
      sp_q   <= sp_d;
      item_q <= item_d;
    end
  end

  assign out_valid_o = s2_valid_q;
  assign out_item_o  = item_q;

endmodule
`default_nettype wire

// ----- rtl/bpi_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bpi_fifo: short queue between front and back
// Register-based FIFO carrying classified items.
// ----------------------------------------------------------------------------
module bpi_fifo (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  bpi_pkg::item_t  push_item_i,
  output logic            full_o,
  input  wire logic       pop_i,
  output bpi_pkg::item_t  pop_item_o,
  output logic            empty_o
);
  localparam int AW = bpi_pkg::FIFO_AW;

  bpi_pkg::item_t      mem_q [bpi_pkg::FIFO_DEPTH];
  logic [AW-1:0]       wptr_q, rptr_q;
  logic [AW:0]         cnt_q;

  assign full_o     = (cnt_q == (AW+1)'(bpi_pkg::FIFO_DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_item_o = mem_q[rptr_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + 1'b1;
      if (pop_i)  rptr_q <= rptr_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (!push_i && pop_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= push_item_i;
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o && !pop_i)) else $error("fifo overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o)) else $error("fifo underflow");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (AW+1)'(bpi_pkg::FIFO_DEPTH)) else $error("fifo count out of range");
`endif

endmodule
`default_nettype wire

// ----- rtl/bpi_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bpi_back: pipelined IoU divider
// One quotient bit per stage; the last stage is the output register.
// ----------------------------------------------------------------------------
module bpi_back (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  bpi_pkg::item_t  in_item_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output bpi_pkg::item_t  out_item_o,
  output logic [bpi_pkg::IOU_BITS-1:0] out_iou_o,
  output logic            out_empty_o
);
  localparam int N = bpi_pkg::DIV_STAGES;

  logic         en;
  logic [N-1:0] valid_q;
  bpi_pkg::div_t st_q [N];
  bpi_pkg::div_t st_d [N];

  assign en         = !(valid_q[N-1] && !out_ready_i);
  assign in_ready_o = en;

  // Restoring division steps; remainder stays below the divisor
  always_comb begin
    for (int k = 0; k < N; k++) begin
      bpi_pkg::div_t      src;
      logic [bpi_pkg::REM_BITS-1:0] r, dv;
      if (k == 0) begin
        src.item = in_item_i;
        src.rem  = bpi_pkg::REM_BITS'(in_item_i.inter);
        src.quo  = '0;
        r        = src.rem;
      end else begin
        src = st_q[k-1];
        r   = {src.rem[bpi_pkg::REM_BITS-2:0], 1'b0};
      end
      dv            = {1'b0, src.item.uni};
      st_d[k].item  = src.item;
      if (r >= dv) begin
        st_d[k].rem = r - dv;
        st_d[k].quo = {src.quo[bpi_pkg::IOU_BITS-2:0], 1'b1};
      end else begin
        st_d[k].rem = r;
        st_d[k].quo = {src.quo[bpi_pkg::IOU_BITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= '0;
    else if (en) valid_q <= {valid_q[N-2:0], in_valid_i};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < N; k++) st_q[k] <= st_d[k];
    end
  end

  // Empty union gives zero IoU
  assign out_valid_o = valid_q[N-1];
  assign out_item_o  = st_q[N-1].item;
  assign out_empty_o = (st_q[N-1].item.uni == '0);
  assign out_iou_o   = out_empty_o ? '0 : st_q[N-1].quo;

endmodule
`default_nettype wire

// ----- rtl/box_pair_iou.sv -----
`default_nettype none
// Path: the registered front, the queue, then 17 divider stages.
// Throughput: one box pair per cycle while the output is not stalled; one quotient bit per divider stage.
// The front and the divider each stall only on their own downstream side.
// Reset (rst_ni low, asynchronous) clears all valid flags and queue pointers.
// ----------------------------------------------------------------------------
// box_pair_iou: intersection over union of two boxes
// Front computes overlaps and areas, a queue decouples, back divides.
// ----------------------------------------------------------------------------
module box_pair_iou (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic s_axis_tvalid,
  output logic      s_axis_tready,
  // box_a_x, box_a_y, box_a_width, box_a_height, box_b_x, box_b_y, box_b_width,
  // box_b_height (12 bits each, from bit 0 up)
  input  wire logic [bpi_pkg::IN_TDATA-1:0] s_axis_tdata,
  output logic      m_axis_tvalid,
  input  wire logic m_axis_tready,
  // intersection_area[23:0], union_area[48:24], iou_fraction[65:49],
  // center_spacing[78:66], zero pad above
  output logic [bpi_pkg::OUT_TDATA-1:0] m_axis_tdata,
  // union_empty
  output logic      m_axis_tuser
);
  logic f_valid, f_ready, q_full, q_empty, b_ready;
  bpi_pkg::item_t f_item, q_item, b_item;
  logic [bpi_pkg::IOU_BITS-1:0] b_iou;

  bpi_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (s_axis_tdata[bpi_pkg::IN_BITS-1:0]),
    .out_valid_o(f_valid),
    .out_ready_i(f_ready),
    .out_item_o (f_item)
  );

  assign f_ready = !q_full;

  bpi_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i     (f_valid && f_ready && s_axis_tready),
    .push_item_i(f_item),
    .full_o     (q_full),
    .pop_i      (b_ready && !q_empty),
    .pop_item_o (q_item),
    .empty_o    (q_empty)
  );

  bpi_back u_back (
    .clk_i, .rst_ni,
    .in_valid_i (!q_empty),
    .in_ready_o (b_ready),
    .in_item_i  (q_item),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_item_o (b_item),
    .out_iou_o  (b_iou),
    .out_empty_o(m_axis_tuser)
  );

  assign m_axis_tdata = bpi_pkg::OUT_TDATA'({b_item.spacing, b_iou, b_item.uni, b_item.inter});

endmodule
`default_nettype wire
